// ===== design/tle_pkg.sv =====
// ----------------------------------------------------------------------------
// tle_pkg
// Shared constants, codes and controller/datapath interface types for the
// terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

    localparam int BUF_DEPTH_DEF = 32;
    localparam int LIMIT_W       = 6;
    localparam int CURSOR_W      = 6;
    localparam int LEN_W         = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

    // Output channel codes.
    localparam logic [1:0] CH_ECHO = 2'd0;
    localparam logic [1:0] CH_LINE = 2'd1;
    localparam logic [1:0] CH_END  = 2'd2;

    // Byte codes of interest.
    localparam logic [7:0] BYTE_BS    = 8'd8;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_SPACE = 8'd32;
    localparam logic [7:0] BYTE_TILDE = 8'd126;
    localparam logic [7:0] BYTE_DEL   = 8'd127;

    // Output word selection codes.
    localparam logic [2:0] SEL_CR   = 3'd0;
    localparam logic [2:0] SEL_LF   = 3'd1;
    localparam logic [2:0] SEL_BS   = 3'd2;
    localparam logic [2:0] SEL_SP   = 3'd3;
    localparam logic [2:0] SEL_CHAR = 3'd4;
    localparam logic [2:0] SEL_LINE = 3'd5;
    localparam logic [2:0] SEL_END  = 3'd6;

    typedef struct packed {
        logic       load_byte;
        logic       dec_cursor;
        logic       store_char;
        logic       clr_cursor;
        logic       idx_clr;
        logic       idx_inc;
        logic       out_load;
        logic [2:0] out_sel;
        logic       out_last;
    } tle_cmd_t;

    typedef struct packed {
        logic is_newline;
        logic erase_ok;
        logic print_ok;
        logic out_free;
        logic line_empty;
        logic idx_last;
    } tle_status_t;

endpackage

// ===== design/tle_ram.sv =====
// ----------------------------------------------------------------------------
// tle_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tle_ctrl.sv =====
// ----------------------------------------------------------------------------
// tle_ctrl
// Sequencer for the line editor: takes a word, classifies it and steps the
// datapath through the echo, line stream and end marker.
// ----------------------------------------------------------------------------
module tle_ctrl
    import tle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  tle_status_t status,
    output tle_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DECODE    = 4'd1;
    localparam logic [3:0] ST_CHAR      = 4'd2;
    localparam logic [3:0] ST_BS1       = 4'd3;
    localparam logic [3:0] ST_BS2       = 4'd4;
    localparam logic [3:0] ST_BS3       = 4'd5;
    localparam logic [3:0] ST_ECHO_CR   = 4'd6;
    localparam logic [3:0] ST_ECHO_LF   = 4'd7;
    localparam logic [3:0] ST_LINE_ADDR = 4'd8;
    localparam logic [3:0] ST_LINE_DATA = 4'd9;
    localparam logic [3:0] ST_END       = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_sel = SEL_CR;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_byte = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_newline)
                begin
                    state_next = ST_ECHO_CR;
                end
                else if (status.erase_ok)
                begin
                    cmd.dec_cursor = 1'b1;
                    state_next     = ST_BS1;
                end
                else if (status.print_ok)
                begin
                    state_next = ST_CHAR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHAR:
            begin
                if (status.out_free)
                begin
                    cmd.store_char = 1'b1;
                    cmd.out_load   = 1'b1;
                    cmd.out_sel    = SEL_CHAR;
                    cmd.out_last   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_BS1, ST_BS3:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_BS;
                    cmd.out_last = (state_reg == ST_BS3);
                    state_next   = (state_reg == ST_BS3) ? ST_IDLE : ST_BS2;
                end
            end
            ST_BS2:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_SP;
                    state_next   = ST_BS3;
                end
            end
            ST_ECHO_CR:
            begin
                cmd.idx_clr = 1'b1;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_CR;
                    state_next   = ST_ECHO_LF;
                end
            end
            ST_ECHO_LF:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_LF;
                    state_next   = status.line_empty ? ST_END : ST_LINE_ADDR;
                end
            end
            ST_LINE_ADDR:
            begin
                // The read address is presented in this state; the data is ready in the next.
                state_next = ST_LINE_DATA;
            end
            ST_LINE_DATA:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_LINE;
                    cmd.idx_inc  = 1'b1;
                    state_next   = status.idx_last ? ST_END : ST_LINE_ADDR;
                end
            end
            ST_END:
            begin
                if (status.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_sel    = SEL_END;
                    cmd.out_last   = 1'b1;
                    cmd.clr_cursor = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/tle_datapath.sv =====
// ----------------------------------------------------------------------------
// tle_datapath
// Holds the received word, cursor, line limit, line store and the output
// register, and carries out the sequencer's commands.
// ----------------------------------------------------------------------------
module tle_datapath
    import tle_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         rx_byte,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [1:0]         channel,
    output logic [7:0]         out_byte,
    output logic [LEN_W-1:0]   line_length,
    output logic               last,
    input  tle_cmd_t           cmd,
    output tle_status_t        status
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam logic [LIMIT_W-1:0] DEPTH_LIM = LIMIT_W'(BUF_DEPTH);

    logic [7:0]          byte_reg;
    logic [CURSOR_W-1:0] cursor_reg;
    logic [CURSOR_W-1:0] idx_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic                out_valid_reg;
    logic [1:0]          channel_reg;
    logic [7:0]          out_byte_reg;
    logic [LEN_W-1:0]    line_length_reg;
    logic                last_reg;

    logic [LIMIT_W-1:0]  lim_eff;
    logic [LIMIT_W-1:0]  cap;
    logic [7:0]          rdata;
    logic [1:0]          channel_next;
    logic [7:0]          out_byte_next;
    logic [LEN_W-1:0]    line_length_next;

    tle_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (cmd.store_char),
        .waddr (cursor_reg[AW-1:0]),
        .wdata (byte_reg),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    // A limit above the store depth acts as the depth; 0 or 1 holds nothing.
    assign lim_eff = (limit_reg > DEPTH_LIM) ? DEPTH_LIM : limit_reg;
    assign cap     = (lim_eff != '0) ? (lim_eff - LIMIT_W'(1)) : '0;

    assign status.is_newline = (byte_reg == BYTE_CR) || (byte_reg == BYTE_LF);
    assign status.erase_ok   = ((byte_reg == BYTE_BS) || (byte_reg == BYTE_DEL))
                               && (cursor_reg != '0);
    assign status.print_ok   = (byte_reg >= BYTE_SPACE) && (byte_reg <= BYTE_TILDE)
                               && (cursor_reg < cap);
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.line_empty = (cursor_reg == '0);
    assign status.idx_last   = ((idx_reg + CURSOR_W'(1)) == cursor_reg);

    always_comb
    begin
        channel_next     = CH_ECHO;
        out_byte_next    = '0;
        line_length_next = '0;
        case (cmd.out_sel)
            SEL_CR:   out_byte_next = BYTE_CR;
            SEL_LF:   out_byte_next = BYTE_LF;
            SEL_BS:   out_byte_next = BYTE_BS;
            SEL_SP:   out_byte_next = BYTE_SPACE;
            SEL_CHAR: out_byte_next = byte_reg;
            SEL_LINE:
            begin
                channel_next  = CH_LINE;
                out_byte_next = rdata;
            end
            SEL_END:
            begin
                channel_next     = CH_END;
                line_length_next = cursor_reg[LEN_W-1:0];
            end
            default:  out_byte_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            idx_reg       <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.clr_cursor)
            begin
                cursor_reg <= '0;
            end
            else if (cmd.dec_cursor)
            begin
                cursor_reg <= cursor_reg - CURSOR_W'(1);
            end
            else if (cmd.store_char)
            begin
                cursor_reg <= cursor_reg + CURSOR_W'(1);
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CURSOR_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            byte_reg <= rx_byte;
        end
        if (cmd.out_load)
        begin
            channel_reg     <= channel_next;
            out_byte_reg    <= out_byte_next;
            line_length_reg <= line_length_next;
            last_reg        <= cmd.out_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign channel     = channel_reg;
    assign out_byte    = out_byte_reg;
    assign line_length = line_length_reg;
    assign last        = last_reg;

endmodule

// ===== design/terminal_line_editor.sv =====
// ----------------------------------------------------------------------------
// terminal_line_editor
// Line editor with echo for a byte-serial terminal.
// ----------------------------------------------------------------------------
// Received terminal bytes arrive one word at a time on the input channel
// (in_valid / in_ready, rx_byte). Each word produces zero or more result
// words on the output channel (out_valid / out_ready) carrying channel,
// out_byte, line_length and last; last marks the final result of a word.
// A printable byte is stored and echoed, backspace or DEL echoes BS SP BS,
// and CR or LF echoes CR LF, streams the held line and closes with an end
// marker that carries the length.
// A word is taken only while the sequencer is idle. On a completed line,
// each line byte needs a read on the single read port of the line store
// before it is presented.
// The output register lets the next word in while the last result waits.
// If the receiver stalls, the sequencer holds at its current step and the
// output word stays unchanged until it is taken.
// Reset clears the cursor, sets line_limit to 32 and empties the output
// register; the line store itself is not cleared, as only written entries
// are ever read. line_limit is written through cfg_we / cfg_wdata.
// ----------------------------------------------------------------------------
module terminal_line_editor
    import tle_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         channel,
    output logic [7:0]         out_byte,
    output logic [LEN_W-1:0]   line_length,
    output logic               last,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata
);

    // Commands from the sequencer and status back from the datapath.
    tle_cmd_t    cmd;
    tle_status_t status;

    tle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tle_datapath #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx_byte),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .channel     (channel),
        .out_byte    (out_byte),
        .line_length (line_length),
        .last        (last),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ===== design/tle_checker.sv =====
// ----------------------------------------------------------------------------
// tle_checker
// Port-level checks on the output words of the line editor.
// ----------------------------------------------------------------------------
module tle_checker
    import tle_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [1:0]       channel,
    input logic [7:0]       out_byte,
    input logic [LEN_W-1:0] line_length,
    input logic             last
);

    // A word taken keeps the input closed while it is decoded.
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again straight after a word");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable(channel) && $stable(out_byte)
            && $stable(line_length) && $stable(last))
        else $error("output word changed while stalled");

    // An end marker closes the word's results and carries no byte.
    a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (channel == CH_END) |-> last && (out_byte == 8'd0))
        else $error("malformed end marker");

    // Line bytes are never final and carry no length.
    a_line_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (channel == CH_LINE) |-> !last && (line_length == '0))
        else $error("malformed line byte");

    // Echo words never carry a length and the channel code is in range.
    a_echo_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (channel != 2'd3)
            && ((channel == CH_END) || (line_length == '0)))
        else $error("malformed echo word");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .channel     (channel),
    .out_byte    (out_byte),
    .line_length (line_length),
    .last        (last)
);

// ===== tb/terminal_line_editor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_line_editor_test
// Self-checking testbench for the terminal line editor with echo.
// ----------------------------------------------------------------------------
// Received bytes are pushed through the input channel and every result word
// is checked against a shadow line editor kept here, one field at a time.
// A short table of hand-picked bytes and limit writes runs first. It covers
// control bytes, printable extremes, erasing, line completion, a full line,
// a zero and an oversized limit, and a limit lowered part way through a line.
// Random lines with edits and noise bytes follow, under several limits.
// Both sides of the block insert random idle cycles in some phases and none
// in others.
// ----------------------------------------------------------------------------
module terminal_line_editor_test;

    import tle_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 244;
    // Cycles allowed after the last expected word before the block is taken
    // to be idle.
    localparam int IDLE_TAIL    = 10;
    localparam int END_TAIL     = 40;
    localparam int MAX_REPORTS  = 50;

    // One result word as it leaves the block.
    typedef struct packed {
        logic [1:0]       chan;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic             fin;
    } editor_word_t;

    typedef enum logic {ROW_RX, ROW_LIMIT} row_kind_t;

    // A row of the directed table.  Where pinned is set, the words that the
    // byte must cause are typed in the row: none, or one echo of echo_byte.
    typedef struct {
        row_kind_t  kind;
        logic [7:0] value;
        bit         pinned;
        int         n_words;
        logic [7:0] echo_byte;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         channel;
    logic [7:0]         out_byte;
    logic [LEN_W-1:0]   line_length;
    logic               last;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;

    // Shadow copy of the editor state and of the line_limit register.
    logic [7:0]         line_shadow [BUF_DEPTH_DEF];
    int unsigned        held_count;
    logic [LIMIT_W-1:0] limit_shadow;

    editor_word_t       fresh_words [$];
    editor_word_t       pending_words [$];
    editor_word_t       want_word;
    editor_word_t       got_word;

    int                 mismatch_count = 0;
    int                 cycle_count;
    int                 recv_hold = 0;
    int                 random_items;
    bit                 send_gaps_on;
    bit                 recv_gaps_on;

    stim_row_t directed_rows [] = '{
        // Control bytes and erase on an empty line cause nothing; then an empty line is completed.
        '{ROW_RX,    BYTE_BS,    1'b1, 0, 8'h00},
        '{ROW_RX,    BYTE_DEL,   1'b1, 0, 8'h00},
        '{ROW_RX,    8'h00,      1'b1, 0, 8'h00},
        '{ROW_RX,    8'hFF,      1'b1, 0, 8'h00},
        '{ROW_RX,    8'h80,      1'b1, 0, 8'h00},
        '{ROW_RX,    8'h1F,      1'b1, 0, 8'h00},
        '{ROW_RX,    8'h09,      1'b1, 0, 8'h00},
        '{ROW_RX,    BYTE_CR,    1'b0, 0, 8'h00},
        // Printable extremes, then both erase codes and a completed line.
        '{ROW_RX,    BYTE_SPACE, 1'b1, 1, BYTE_SPACE},
        '{ROW_RX,    BYTE_TILDE, 1'b1, 1, BYTE_TILDE},
        '{ROW_RX,    8'h41,      1'b1, 1, 8'h41},
        '{ROW_RX,    BYTE_BS,    1'b0, 0, 8'h00},
        '{ROW_RX,    BYTE_DEL,   1'b0, 0, 8'h00},
        '{ROW_RX,    8'h30,      1'b1, 1, 8'h30},
        '{ROW_RX,    BYTE_LF,    1'b0, 0, 8'h00},
        // Smallest useful limit: one character, the next one is dropped.
        '{ROW_LIMIT, 8'd2,       1'b0, 0, 8'h00},
        '{ROW_RX,    8'h78,      1'b1, 1, 8'h78},
        '{ROW_RX,    8'h79,      1'b1, 0, 8'h00},
        '{ROW_RX,    BYTE_CR,    1'b0, 0, 8'h00},
        // A limit of zero holds nothing.
        '{ROW_LIMIT, 8'd0,       1'b0, 0, 8'h00},
        '{ROW_RX,    8'h7A,      1'b1, 0, 8'h00},
        '{ROW_RX,    BYTE_LF,    1'b0, 0, 8'h00},
        // Oversized limit, then the limit lowered under a held line.
        '{ROW_LIMIT, 8'd63,      1'b0, 0, 8'h00},
        '{ROW_RX,    8'h61,      1'b1, 1, 8'h61},
        '{ROW_RX,    8'h62,      1'b1, 1, 8'h62},
        '{ROW_LIMIT, 8'd2,       1'b0, 0, 8'h00},
        '{ROW_RX,    8'h63,      1'b1, 0, 8'h00},
        '{ROW_RX,    BYTE_CR,    1'b0, 0, 8'h00},
        // A limit of one holds nothing either.
        '{ROW_LIMIT, 8'd1,       1'b0, 0, 8'h00},
        '{ROW_RX,    8'h64,      1'b1, 0, 8'h00},
        '{ROW_RX,    BYTE_DEL,   1'b1, 0, 8'h00},
        '{ROW_LIMIT, 8'd32,      1'b0, 0, 8'h00}
    };

    terminal_line_editor dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .channel     (channel),
        .out_byte    (out_byte),
        .line_length (line_length),
        .last        (last),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow editor
    // ------------------------------------------------------------------------

    function automatic void emit_word(input logic [1:0] chan, input logic [7:0] data,
                                      input int unsigned len, input logic fin);
        editor_word_t w;
        w.chan = chan;
        w.data = data;
        w.len  = len[LEN_W-1:0];
        w.fin  = fin;
        fresh_words.push_back(w);
    endfunction

    // Works out the words that one received byte causes and updates the
    // shadow line.  The words are left in fresh_words.
    function automatic void edit_line(input logic [7:0] ch);
        int unsigned usable;
        int unsigned room;
        int unsigned line_len;
        fresh_words.delete();
        // A limit above the buffer depth acts as the depth; one slot is
        // always kept back, so a limit of zero or one holds nothing.
        usable = (limit_shadow > BUF_DEPTH_DEF) ? BUF_DEPTH_DEF : limit_shadow;
        room   = (usable >= 1) ? usable - 1 : 0;
        if (ch == BYTE_CR || ch == BYTE_LF)
        begin
            line_len = (held_count > BUF_DEPTH_DEF - 1) ? BUF_DEPTH_DEF - 1 : held_count;
            emit_word(CH_ECHO, BYTE_CR, 0, 1'b0);
            emit_word(CH_ECHO, BYTE_LF, 0, 1'b0);
            for (int i = 0; i < line_len; i++)
            begin
                emit_word(CH_LINE, line_shadow[i], 0, 1'b0);
            end
            emit_word(CH_END, 8'h00, line_len, 1'b1);
            held_count = 0;
        end
        else if (ch == BYTE_BS || ch == BYTE_DEL)
        begin
            if (held_count > 0)
            begin
                held_count--;
                emit_word(CH_ECHO, BYTE_BS, 0, 1'b0);
                emit_word(CH_ECHO, BYTE_SPACE, 0, 1'b0);
                emit_word(CH_ECHO, BYTE_BS, 0, 1'b1);
            end
        end
        else if (ch >= BYTE_SPACE && ch <= BYTE_TILDE && held_count < room)
        begin
            line_shadow[held_count] = ch;
            held_count++;
            emit_word(CH_ECHO, ch, 0, 1'b1);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(input string note, input editor_word_t got,
                                 input editor_word_t want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $write("%0t: %s: got ch=%0d byte=%02h len=%0d last=%0b, ",
                   $time, note, got.chan, got.data, got.len, got.fin);
            $display("want ch=%0d byte=%02h len=%0d last=%0b",
                     want.chan, want.data, want.len, want.fin);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: the receiver stalls for a random number of cycles after
    // each word it takes, in phases where stalls are switched on.
    // ------------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (recv_hold > 0)
        begin
            out_ready <= 1'b0;
            recv_hold = recv_hold - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Each word taken is compared with the oldest outstanding expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_word.chan = channel;
            got_word.data = out_byte;
            got_word.len  = line_length;
            got_word.fin  = last;
            if (pending_words.size() == 0)
            begin
                want_word = '0;
                flag_mismatch("word with nothing expected", got_word, want_word);
            end
            else
            begin
                want_word = pending_words.pop_front();
                if (got_word.chan !== want_word.chan || got_word.data !== want_word.data ||
                    got_word.len !== want_word.len || got_word.fin !== want_word.fin)
                begin
                    flag_mismatch("word mismatch", got_word, want_word);
                end
            end
            recv_hold = recv_gaps_on ? $urandom_range(0, 14) : 0;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Presents one byte, waits for it to be taken and records the words it
    // should cause.  For a pinned row the typed words stand in for the
    // shadow editor's, though the shadow state still moves on.
    task automatic send_rx(input logic [7:0] value, input bit pinned,
                           input int n_fixed, input logic [7:0] echo_fixed);
        int gap;
        editor_word_t fixed_word;
        gap = send_gaps_on ? $urandom_range(0, 14) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        do @(posedge clk); while (!in_ready);
        edit_line(value);
        if (pinned)
        begin
            fresh_words.delete();
            if (n_fixed == 1)
            begin
                fixed_word.chan = CH_ECHO;
                fixed_word.data = echo_fixed;
                fixed_word.len  = '0;
                fixed_word.fin  = 1'b1;
                fresh_words.push_back(fixed_word);
            end
        end
        foreach (fresh_words[i])
        begin
            pending_words.push_back(fresh_words[i]);
        end
    endtask

    // Drops valid and waits until every expected word has come out, then
    // lets the block finish any byte that causes no word.
    task automatic drain_editor();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        drain_editor();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        limit_shadow = value;
    endtask

    // Picks a limit for a random phase, with the extremes drawn often.
    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0: return 6'd2;
            1: return 6'd32;
            2: return 6'd63;
            3: return 6'd0;
            4: return 6'd1;
            5: return LIMIT_W'($urandom_range(0, 63));
            default: return LIMIT_W'($urandom_range(2, 32));
        endcase
    endfunction

    // Draws one byte inside a line: mostly printable, some erases and some
    // bytes from the whole range as noise.
    function automatic logic [7:0] pick_line_byte();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 78)
            return 8'($urandom_range(BYTE_SPACE, BYTE_TILDE));
        else if (roll < 88)
            return ($urandom_range(0, 1) != 0) ? BYTE_BS : BYTE_DEL;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("terminal_line_editor_test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        int unsigned room;
        int unsigned line_len;
        int          n_lines;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        rx_byte      = 8'h00;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        send_gaps_on = 1'b0;
        recv_gaps_on = 1'b0;
        held_count   = 0;
        limit_shadow = LIMIT_RESET;
        foreach (line_shadow[i])
        begin
            line_shadow[i] = 8'h00;
        end

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, walked with no idling on either side.
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_LIMIT)
                write_limit(directed_rows[r].value[LIMIT_W-1:0]);
            else
                send_rx(directed_rows[r].value, directed_rows[r].pinned,
                        directed_rows[r].n_words, directed_rows[r].echo_byte);
        end

        // Random part.  Each phase sets a limit, chooses whether the two
        // sides idle, and sends a few lines with edits and noise.  Most lines
        // end in CR or LF; the rest run on, also into the next phase, so the
        // limit also changes under a partly typed line.  Every byte sent is counted.
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            write_limit(pick_limit());
            send_gaps_on = ($urandom_range(0, 3) != 0);
            recv_gaps_on = ($urandom_range(0, 3) != 0);
            n_lines      = $urandom_range(1, 3);
            for (int k = 0; k < n_lines; k++)
            begin
                room = (limit_shadow > BUF_DEPTH_DEF) ? BUF_DEPTH_DEF - 1 :
                       (limit_shadow >= 1) ? limit_shadow - 1 : 0;
                // Lines may run past the limit so that the full line is met.
                line_len = $urandom_range(0, room + 3);
                for (int j = 0; j < line_len; j++)
                begin
                    send_rx(pick_line_byte(), 1'b0, 0, 8'h00);
                    random_items++;
                end
                if ($urandom_range(0, 9) != 0)
                begin
                    send_rx(($urandom_range(0, 1) != 0) ? BYTE_CR : BYTE_LF, 1'b0, 0, 8'h00);
                    random_items++;
                end
                // Now and then the sender holds back until the block has
                // emptied completely.
                if ($urandom_range(0, 3) == 0)
                    drain_editor();
            end
        end

        drain_editor();
        repeat (END_TAIL) @(posedge clk);
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("terminal_line_editor_test passed");
        else
            $display("terminal_line_editor_test failed");
        $finish;
    end

endmodule

// ===== terminal_line_editor.f =====
design/tle_pkg.sv
design/tle_ram.sv
design/tle_ctrl.sv
design/tle_datapath.sv
design/terminal_line_editor.sv
design/tle_checker.sv
tb/terminal_line_editor_test.sv
